[hw/rtl/pmfp_pkg.sv]
// Package: shared constants and types for the particulate sensor frame parser.
`timescale 1ns / 1ps
package pmfp_pkg;

  // Frame kinds, as held in the configuration register and reported per result;
  // the register takes all four codes and the last one matches no frame
  localparam logic [1:0] KIND_QUERY  = 2'd0;
  localparam logic [1:0] KIND_UPLOAD = 2'd1;
  localparam logic [1:0] KIND_ACK    = 2'd2;
  localparam logic [1:0] KIND_NONE   = 2'd3;

  // Start and identifier bytes
  localparam logic [7:0] CMD_START_BYTE = 8'hFF;
  localparam logic [7:0] QUERY_ID_BYTE  = 8'h86;
  localparam logic [7:0] ACK_ID_BYTE    = 8'hA7;
  localparam logic [7:0] UPL_START_BYTE = 8'h42;
  localparam logic [7:0] UPL_ID_BYTE    = 8'h4D;
  localparam logic [7:0] UPL_LEN_OK     = 8'd20;

  // Frame positions
  localparam logic [4:0] POS_HUNT     = 5'd0;
  localparam logic [4:0] POS_ID       = 5'd1;
  localparam logic [4:0] POS_DONE     = 5'd31;
  localparam logic [4:0] CMD_LAST     = 5'd8;
  localparam logic [4:0] UPL_LEN_POS  = 5'd3;
  localparam logic [4:0] UPL_SUM_LAST = 5'd21;
  localparam logic [4:0] UPL_CS_HI    = 5'd22;
  localparam logic [4:0] UPL_LAST     = 5'd23;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_CSUM_ERR = 3'd1,
    ST_NO_FRAME = 3'd2,
    ST_REFUSED  = 3'd3,
    ST_BAD_LEN  = 3'd4
  } status_e;

endpackage

[hw/rtl/pmfp_if.sv]
// Interfaces: byte input, result output and configuration write channels.
`timescale 1ns / 1ps
interface pmfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       end_of_buffer;

  modport source (output valid, output rx_byte, output end_of_buffer, input ready);
  modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

interface pmfp_res_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [1:0]  frame_kind;
  logic [15:0] pm1_value;
  logic [15:0] pm2_5_value;
  logic [15:0] pm10_value;

  modport source (output valid, output status, output frame_kind, output pm1_value,
                  output pm2_5_value, output pm10_value, input ready);
  modport sink   (input valid, input status, input frame_kind, input pm1_value,
                  input pm2_5_value, input pm10_value, output ready);
endinterface

interface pmfp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] expected_kind;

  modport source (output valid, output expected_kind, input ready);
  modport sink   (input valid, input expected_kind, output ready);
endinterface

[hw/rtl/pm_sensor_frame_parser_core.sv]
// Top level: particulate sensor receive-frame parser with a registered result port.
// Result: registered, and shown on res_o in the cycle after the transfer of the byte causing it.
// Throughput: one byte per cycle; the result register frees in the cycle it is taken,
//   so the byte port stalls only while a shown result is refused by the sink.
// Reset: rst_ni clears the frame state, the result valid and the kind register (query
//   response); the parser starts out hunting for a start byte.
`timescale 1ns / 1ps
module pm_sensor_frame_parser_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  pmfp_byte_if.sink   byte_i,
  pmfp_cfg_if.sink    cfg_i,
  pmfp_res_if.source  res_o
);

  // Configuration register and per-frame parse state
  logic [1:0]  kind_q, kind_d;
  logic [4:0]  pos_q, pos_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  len_q, len_d;
  logic [15:0] pm1_q, pm1_d;
  logic [15:0] pm25_q, pm25_d;
  logic [15:0] pm10_q, pm10_d;
  logic [7:0]  cs_hi_q, cs_hi_d;
  logic        ack_q, ack_d;

  // Result register
  logic        res_valid_q;
  logic [2:0]  res_status_q;
  logic [1:0]  res_kind_q;
  logic [15:0] res_pm1_q, res_pm25_q, res_pm10_q;

  // Result of this byte, if any
  logic              hit;
  pmfp_pkg::status_e hit_status;
  logic [15:0]       hit_pm1, hit_pm25, hit_pm10;

  logic       byte_fire, cfg_fire;
  logic       has_start;
  logic [7:0] start_b, id_b, b;
  logic       eob;
  logic [7:0] cmd_sum;
  logic [7:0] cmd_expect;
  logic [15:0] upl_sent;

  // Accept a byte whenever the result register is empty or being emptied
  assign byte_i.ready = !res_valid_q || res_o.ready;
  assign cfg_i.ready  = 1'b1;
  assign byte_fire    = byte_i.valid && byte_i.ready;
  assign cfg_fire     = cfg_i.valid;

  assign b   = byte_i.rx_byte;
  assign eob = byte_i.end_of_buffer;

  // Start and identifier bytes of the kind sought; the unused kind never starts
  assign has_start = (kind_q != pmfp_pkg::KIND_NONE);
  assign start_b   = (kind_q == pmfp_pkg::KIND_UPLOAD) ? pmfp_pkg::UPL_START_BYTE
                                                       : pmfp_pkg::CMD_START_BYTE;
  assign id_b      = (kind_q == pmfp_pkg::KIND_QUERY)  ? pmfp_pkg::QUERY_ID_BYTE :
                     (kind_q == pmfp_pkg::KIND_ACK)    ? pmfp_pkg::ACK_ID_BYTE
                                                       : pmfp_pkg::UPL_ID_BYTE;

  // Command frames keep an 8-bit sum; the check byte is its two's complement
  assign cmd_sum    = sum_q[7:0] + b;
  assign cmd_expect = 8'd0 - sum_q[7:0];
  assign upl_sent   = {cs_hi_q, b};

  always_comb begin
    kind_d     = kind_q;
    pos_d      = pos_q;
    sum_d      = sum_q;
    len_d      = len_q;
    pm1_d      = pm1_q;
    pm25_d     = pm25_q;
    pm10_d     = pm10_q;
    cs_hi_d    = cs_hi_q;
    ack_d      = ack_q;
    hit        = 1'b0;
    hit_status = pmfp_pkg::ST_OK;
    hit_pm1    = '0;
    hit_pm25   = '0;
    hit_pm10   = '0;

    if (cfg_fire) begin
      // A register write abandons any partial frame and the reported mark
      kind_d = cfg_i.expected_kind;
      pos_d  = pmfp_pkg::POS_HUNT;
      sum_d  = '0;
    end else if (byte_fire) begin
      if (pos_q == pmfp_pkg::POS_DONE) begin
        // Burst already reported: drop the byte
      end else if (pos_q == pmfp_pkg::POS_HUNT) begin
        if (has_start && (b == start_b)) begin
          pos_d = pmfp_pkg::POS_ID;
          sum_d = (kind_q == pmfp_pkg::KIND_UPLOAD) ? {8'd0, b} : 16'd0;
        end
      end else if (pos_q == pmfp_pkg::POS_ID) begin
        if (b == id_b) begin
          sum_d = sum_q + {8'd0, b};
          pos_d = 5'd2;
        end else if (b == start_b) begin
          // Repeated start byte: restart the frame here
          pos_d = pmfp_pkg::POS_ID;
          sum_d = (kind_q == pmfp_pkg::KIND_UPLOAD) ? {8'd0, b} : 16'd0;
        end else begin
          pos_d = pmfp_pkg::POS_HUNT;
          sum_d = '0;
        end
      end else if (kind_q != pmfp_pkg::KIND_UPLOAD) begin
        // Nine-byte command frame
        if (pos_q < pmfp_pkg::CMD_LAST) begin
          sum_d = {8'd0, cmd_sum};
          case (pos_q)
            5'd2: begin
              pm1_d[15:8] = b;
              ack_d       = (b != 8'd0);
            end
            5'd3:    pm1_d[7:0]   = b;
            5'd4:    pm10_d[15:8] = b;
            5'd5:    pm10_d[7:0]  = b;
            5'd6:    pm25_d[15:8] = b;
            default: pm25_d[7:0]  = b;
          endcase
          pos_d = pos_q + 5'd1;
        end else begin
          hit   = 1'b1;
          pos_d = pmfp_pkg::POS_DONE;
          if (cmd_expect != b) begin
            hit_status = pmfp_pkg::ST_CSUM_ERR;
          end else if (kind_q == pmfp_pkg::KIND_QUERY) begin
            hit_status = pmfp_pkg::ST_OK;
            hit_pm1    = pm1_q;
            hit_pm25   = pm25_q;
            hit_pm10   = pm10_q;
          end else begin
            hit_status = ack_q ? pmfp_pkg::ST_OK : pmfp_pkg::ST_REFUSED;
          end
        end
      end else begin
        // 24-byte upload frame
        if (pos_q < pmfp_pkg::UPL_LAST) begin
          if (pos_q <= pmfp_pkg::UPL_SUM_LAST) begin
            sum_d = sum_q + {8'd0, b};
          end
          case (pos_q)
            pmfp_pkg::UPL_LEN_POS: len_d = b;
            5'd10:                 pm1_d[15:8]  = b;
            5'd11:                 pm1_d[7:0]   = b;
            5'd12:                 pm25_d[15:8] = b;
            5'd13:                 pm25_d[7:0]  = b;
            5'd14:                 pm10_d[15:8] = b;
            5'd15:                 pm10_d[7:0]  = b;
            pmfp_pkg::UPL_CS_HI:   cs_hi_d = b;
            default: ;
          endcase
          pos_d = pos_q + 5'd1;
        end else begin
          hit   = 1'b1;
          pos_d = pmfp_pkg::POS_DONE;
          // A bad length outranks a checksum error
          if (len_q != pmfp_pkg::UPL_LEN_OK) begin
            hit_status = pmfp_pkg::ST_BAD_LEN;
          end else if (upl_sent != sum_q) begin
            hit_status = pmfp_pkg::ST_CSUM_ERR;
          end else begin
            hit_status = pmfp_pkg::ST_OK;
            hit_pm1    = pm1_q;
            hit_pm25   = pm25_q;
            hit_pm10   = pm10_q;
          end
        end
      end

      // End of burst: report a missing frame unless one was already reported, then go back to hunting
      if (eob) begin
        if (!hit && (pos_d != pmfp_pkg::POS_DONE)) begin
          hit        = 1'b1;
          hit_status = pmfp_pkg::ST_NO_FRAME;
          hit_pm1    = '0;
          hit_pm25   = '0;
          hit_pm10   = '0;
        end
        pos_d = pmfp_pkg::POS_HUNT;
        sum_d = '0;
      end
    end
  end

  // Parse state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q  <= pmfp_pkg::KIND_QUERY;
      pos_q   <= pmfp_pkg::POS_HUNT;
      sum_q   <= '0;
      len_q   <= '0;
      pm1_q   <= '0;
      pm25_q  <= '0;
      pm10_q  <= '0;
      cs_hi_q <= '0;
      ack_q   <= 1'b0;
    end else begin
      kind_q  <= kind_d;
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      len_q   <= len_d;
      pm1_q   <= pm1_d;
      pm25_q  <= pm25_d;
      pm10_q  <= pm10_d;
      cs_hi_q <= cs_hi_d;
      ack_q   <= ack_d;
    end
  end

  // Result valid: load on a new result, drop once the sink has taken it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (byte_fire && hit) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  // Result payload: hold while stalled
  always_ff @(posedge clk_i) begin
    if (byte_fire && hit) begin
      res_status_q <= hit_status;
      res_kind_q   <= kind_q;
      res_pm1_q    <= hit_pm1;
      res_pm25_q   <= hit_pm25;
      res_pm10_q   <= hit_pm10;
    end
  end

  assign res_o.valid       = res_valid_q;
  assign res_o.status      = res_status_q;
  assign res_o.frame_kind  = res_kind_q;
  assign res_o.pm1_value   = res_pm1_q;
  assign res_o.pm2_5_value = res_pm25_q;
  assign res_o.pm10_value  = res_pm10_q;

endmodule

[hw/rtl/pmfp_checker.sv]
// Checker: port-level assertions for the frame parser, bound to the top level.
`timescale 1ns / 1ps
module pmfp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        byte_valid_i,
  input logic        byte_ready_i,
  input logic        res_valid_i,
  input logic        res_ready_i,
  input logic [2:0]  status_i,
  input logic [1:0]  frame_kind_i,
  input logic [15:0] pm1_i,
  input logic [15:0] pm25_i,
  input logic [15:0] pm10_i
);

  // A stalled result stays shown
  a_res_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_res_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> $stable(status_i) && $stable(frame_kind_i)
      && $stable(pm1_i) && $stable(pm25_i) && $stable(pm10_i))
    else $error("result payload changed while stalled");

  // Only a good frame carries concentrations
  a_zero_pm: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (status_i != pmfp_pkg::ST_OK) |->
      (pm1_i == 16'd0) && (pm25_i == 16'd0) && (pm10_i == 16'd0))
    else $error("concentrations on a failed result");

  // A fresh result follows a byte transfer
  a_res_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(res_valid_i) |-> $past(byte_valid_i && byte_ready_i))
    else $error("result without a byte transfer");

endmodule

bind pm_sensor_frame_parser_core pmfp_checker u_pmfp_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .byte_valid_i (byte_i.valid),
  .byte_ready_i (byte_i.ready),
  .res_valid_i  (res_o.valid),
  .res_ready_i  (res_o.ready),
  .status_i     (res_o.status),
  .frame_kind_i (res_o.frame_kind),
  .pm1_i        (res_o.pm1_value),
  .pm25_i       (res_o.pm2_5_value),
  .pm10_i       (res_o.pm10_value)
);
